### rtl/rgblab_pkg.sv
// Shared constants, types and the sRGB linearization table for the CIELAB converter.
`timescale 1ns / 1ps

package rgblab_pkg;

    // matrix coefficients, Q16
    localparam logic [15:0] MX_R = 16'd27031;
    localparam logic [15:0] MX_G = 16'd23434;
    localparam logic [15:0] MX_B = 16'd11824;
    localparam logic [15:0] MY_R = 16'd13938;
    localparam logic [15:0] MY_G = 16'd46869;
    localparam logic [15:0] MY_B = 16'd4730;
    localparam logic [15:0] MZ_R = 16'd1267;
    localparam logic [15:0] MZ_G = 16'd7811;
    localparam logic [15:0] MZ_B = 16'd62274;

    // D65 white point, Q16, and reciprocals scaled by 2^34
    localparam logic [15:0] WHITE_X = 16'd62289;
    localparam logic [16:0] WHITE_Z = 17'd71353;
    localparam int          WHITE_SHIFT = 34;
    localparam logic [18:0] RECIP_X = 19'((64'd1 << WHITE_SHIFT) / 64'(WHITE_X));
    localparam logic [18:0] RECIP_Z = 19'((64'd1 << WHITE_SHIFT) / 64'(WHITE_Z));

    // Lab f(): knee and linear segment 903292*t + 1048634000 over 116000
    localparam logic [16:0] F_KNEE     = 17'd580;
    localparam logic [19:0] LIN_SLOPE  = 20'd903292;
    localparam logic [30:0] LIN_OFFSET = 31'd1048634000;
    localparam logic [16:0] LIN_DIV    = 17'd116000;
    localparam int          LIN_SHIFT  = 32;
    localparam logic [15:0] RECIP_LIN  = 16'((64'd1 << LIN_SHIFT) / 64'(LIN_DIV));
    localparam int          CBRT_STEPS = 17;

    localparam int L_MAX = 25600;

    localparam int FIFO_DEPTH = 4;

    // normalized XYZ word passed from front to back
    typedef struct packed {
        logic [16:0] zn;
        logic [16:0] yn;
        logic [16:0] xn;
    } xyz_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

    typedef logic [16:0] lin_table_t [256];

    // one entry of the sRGB linearization curve, Q1.16
    function automatic logic [16:0] lin_entry(input int c);
        logic [63:0] cc;
        logic [63:0] t;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] p;
        logic [63:0] res;
        cc = 64'(c);
        r  = '0;
        if (cc <= 64'd10)
        begin
            res = (cc * 64'd6553600 + 64'd164730) / 64'd329460;
        end
        else
        begin
            t = ((64'd1000 * cc + 64'd14025) << 30) / 64'd269025;
            q = (t * t) >> 30;
            for (int k = 30; k >= 0; k--)
            begin
                cand = r | (64'd1 << k);
                p = cand;
                for (int i = 0; i < 4; i++)
                begin
                    p = (p * cand) >> 30;
                end
                if (cand <= (64'd1 << 30) && p <= q)
                begin
                    r = cand;
                end
            end
            res = (((q * r) >> 30) + 64'd8192) >> 14;
        end
        return res[16:0];
    endfunction

    function automatic lin_table_t build_lin_table();
        lin_table_t tbl;
        for (int c = 0; c < 256; c++)
        begin
            tbl[c] = lin_entry(c);
        end
        return tbl;
    endfunction

    localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

### rtl/rgblab_front.sv
// Front pipeline: linearization, RGB to XYZ matrix and white point normalization.
`timescale 1ns / 1ps

module rgblab_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    output logic               out_valid,
    output rgblab_pkg::xyz_t   xyz
);

    logic [4:0] v_reg;

    // F0: captured pixel
    logic [7:0]  r0_reg, g0_reg, b0_reg;
    // F1: linear channels
    logic [16:0] lr1_reg, lg1_reg, lb1_reg;
    // F2: matrix sums, Q32
    logic [31:0] xs2_reg;
    logic [32:0] ys2_reg, zs2_reg;
    // F3: quotient estimates
    logic [32:0] nx3_reg, nz3_reg;
    logic [16:0] qx3_reg, qz3_reg, y3_reg;
    // F4: corrected quotients
    logic [16:0] x4_reg, y4_reg, z4_reg;

    logic [33:0] xs_next, ys_next, zs_next;
    logic [32:0] nx, nz;
    logic [51:0] px, pz;
    logic [33:0] y_round;
    logic [32:0] remx, remz;

    always_comb
    begin
        xs_next = 34'(lr1_reg) * 34'(rgblab_pkg::MX_R) + 34'(lg1_reg) * 34'(rgblab_pkg::MX_G)
                + 34'(lb1_reg) * 34'(rgblab_pkg::MX_B);
        ys_next = 34'(lr1_reg) * 34'(rgblab_pkg::MY_R) + 34'(lg1_reg) * 34'(rgblab_pkg::MY_G)
                + 34'(lb1_reg) * 34'(rgblab_pkg::MY_B);
        zs_next = 34'(lr1_reg) * 34'(rgblab_pkg::MZ_R) + 34'(lg1_reg) * 34'(rgblab_pkg::MZ_G)
                + 34'(lb1_reg) * 34'(rgblab_pkg::MZ_B);

        // round half up, then divide via a reciprocal multiply; estimate is exact or one low
        nx = 33'(xs2_reg) + 33'(rgblab_pkg::WHITE_X >> 1);
        nz = zs2_reg + 33'(rgblab_pkg::WHITE_Z >> 1);
        px = 52'(nx) * 52'(rgblab_pkg::RECIP_X);
        pz = 52'(nz) * 52'(rgblab_pkg::RECIP_Z);
        y_round = 34'(ys2_reg) + 34'd32768;

        remx = nx3_reg - 33'(qx3_reg) * 33'(rgblab_pkg::WHITE_X);
        remz = nz3_reg - 33'(qz3_reg) * 33'(rgblab_pkg::WHITE_Z);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r0_reg  <= red;
            g0_reg  <= green;
            b0_reg  <= blue;
            lr1_reg <= rgblab_pkg::LIN_TABLE[r0_reg];
            lg1_reg <= rgblab_pkg::LIN_TABLE[g0_reg];
            lb1_reg <= rgblab_pkg::LIN_TABLE[b0_reg];
            xs2_reg <= xs_next[31:0];
            ys2_reg <= ys_next[32:0];
            zs2_reg <= zs_next[32:0];
            nx3_reg <= nx;
            nz3_reg <= nz;
            qx3_reg <= px[50:34];
            qz3_reg <= pz[50:34];
            y3_reg  <= y_round[32:16];
            x4_reg  <= qx3_reg + 17'(remx >= 33'(rgblab_pkg::WHITE_X));
            z4_reg  <= qz3_reg + 17'(remz >= 33'(rgblab_pkg::WHITE_Z));
            y4_reg  <= y3_reg;
        end
    end

    assign out_valid = v_reg[4];
    assign xyz.xn    = x4_reg;
    assign xyz.yn    = y4_reg;
    assign xyz.zn    = z4_reg;

endmodule

### rtl/rgblab_fifo.sv
// Small register queue between the front and back pipelines.
`timescale 1ns / 1ps

module rgblab_fifo #(
    parameter int DEPTH = rgblab_pkg::FIFO_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  rgblab_pkg::xyz_t         din,
    input  logic                     pop,
    output rgblab_pkg::xyz_t         dout,
    output rgblab_pkg::fifo_status_t status
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rgblab_pkg::xyz_t mem_reg [DEPTH];
    logic [PW-1:0] wr_reg, rd_reg;
    logic [CW-1:0] cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

    assign dout         = mem_reg[rd_reg];
    assign status.full  = (cnt_reg == CW'(DEPTH));
    assign status.empty = (cnt_reg == '0);

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

    a_cnt_up: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

### rtl/rgblab_flane.sv
// One Lab f() lane: 17-stage cube root with a parallel linear segment.
`timescale 1ns / 1ps

module rgblab_flane (
    input  logic        clk,
    input  logic        en,
    input  logic [16:0] t,
    output logic [16:0] f
);

    localparam int STEPS = rgblab_pkg::CBRT_STEPS;
    localparam int LIN_STAGES = 4;

    logic [16:0] r_reg   [STEPS];
    logic [33:0] r2_reg  [STEPS];
    logic [50:0] r3_reg  [STEPS];
    logic [48:0] tgt_reg [STEPS];
    logic        knee_reg [STEPS];

    // cube root, one result bit per stage; r^2 and r^3 kept incrementally
    for (genvar s = 0; s < STEPS; s++)
    begin : g_cbrt
        localparam int B = STEPS - 1 - s;
        logic [16:0] r_in;
        logic [33:0] r2_in;
        logic [50:0] r3_in;
        logic [48:0] tgt_in;
        logic [16:0] cand;
        logic [34:0] c2;
        logic [52:0] c3;

        if (s == 0)
        begin : g_first
            assign r_in   = '0;
            assign r2_in  = '0;
            assign r3_in  = '0;
            assign tgt_in = {t, 32'd0};
        end
        else
        begin : g_next
            assign r_in   = r_reg[s-1];
            assign r2_in  = r2_reg[s-1];
            assign r3_in  = r3_reg[s-1];
            assign tgt_in = tgt_reg[s-1];
        end

        always_comb
        begin
            cand = r_in | (17'd1 << B);
            c2 = 35'(r2_in) + (35'(r_in) << (B + 1)) + (35'd1 << (2 * B));
            c3 = 53'(r3_in) + (53'(r2_in) << B) + (53'(r2_in) << (B + 1))
               + (53'(r_in) << (2 * B)) + (53'(r_in) << (2 * B + 1))
               + (53'd1 << (3 * B));
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tgt_reg[s] <= tgt_in;
                if (c3 <= 53'(tgt_in))
                begin
                    r_reg[s]  <= cand;
                    r2_reg[s] <= c2[33:0];
                    r3_reg[s] <= c3[50:0];
                end
                else
                begin
                    r_reg[s]  <= r_in;
                    r2_reg[s] <= r2_in;
                    r3_reg[s] <= r3_in;
                end
            end
        end
    end

    // linear segment: reciprocal multiply, one-step correction
    logic [30:0] num0_reg, num1_reg;
    logic [46:0] prod1_reg;
    logic [14:0] est2_reg;
    logic [30:0] rem2_reg;
    logic [14:0] lin_reg [STEPS - LIN_STAGES + 1];
    logic [14:0] est;

    assign est = prod1_reg[46:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num0_reg   <= 31'(t[9:0]) * 31'(rgblab_pkg::LIN_SLOPE) + rgblab_pkg::LIN_OFFSET;
            num1_reg   <= num0_reg;
            prod1_reg  <= 47'(num0_reg) * 47'(rgblab_pkg::RECIP_LIN);
            est2_reg   <= est;
            rem2_reg   <= num1_reg - 31'(est) * 31'(rgblab_pkg::LIN_DIV);
            lin_reg[0] <= est2_reg + 15'(rem2_reg >= 31'(rgblab_pkg::LIN_DIV));
            for (int i = 1; i <= STEPS - LIN_STAGES; i++)
            begin
                lin_reg[i] <= lin_reg[i-1];
            end
            knee_reg[0] <= (t > rgblab_pkg::F_KNEE);
            for (int i = 1; i < STEPS; i++)
            begin
                knee_reg[i] <= knee_reg[i-1];
            end
        end
    end

    assign f = knee_reg[STEPS-1] ? r_reg[STEPS-1] : 17'(lin_reg[STEPS - LIN_STAGES]);

endmodule

### rtl/rgblab_back.sv
// Back pipeline: three f() lanes, Lab combination, rounding and saturation.
`timescale 1ns / 1ps

module rgblab_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  rgblab_pkg::xyz_t    xyz,
    output logic                en,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [14:0]         lightness,
    output logic signed [15:0]  green_red_axis,
    output logic signed [15:0]  blue_yellow_axis
);

    localparam int STEPS = rgblab_pkg::CBRT_STEPS;

    logic [STEPS-1:0] v_reg;
    logic             c1_valid_reg;
    logic             out_valid_reg;

    logic [16:0] fx, fy, fz;
    logic signed [27:0] l16_reg, a16_reg, b16_reg;
    logic signed [27:0] fx_s, fy_s, fz_s;
    logic signed [27:0] lr, ar, br;
    logic [14:0]        l_next;
    logic signed [15:0] a_next, b_next;
    logic [14:0]        l_reg;
    logic signed [15:0] a_reg, b_reg;

    assign en = !out_valid_reg || out_ready;

    rgblab_flane u_lane_x (.clk(clk), .en(en), .t(xyz.xn), .f(fx));
    rgblab_flane u_lane_y (.clk(clk), .en(en), .t(xyz.yn), .f(fy));
    rgblab_flane u_lane_z (.clk(clk), .en(en), .t(xyz.zn), .f(fz));

    always_comb
    begin
        fx_s = signed'(28'(fx));
        fy_s = signed'(28'(fy));
        fz_s = signed'(28'(fz));

        // Q16 to Q8, round half up
        lr = (l16_reg + 28'sd128) >>> 8;
        ar = (a16_reg + 28'sd128) >>> 8;
        br = (b16_reg + 28'sd128) >>> 8;

        if (lr < 28'sd0)
        begin
            l_next = '0;
        end
        else if (lr > 28'(rgblab_pkg::L_MAX))
        begin
            l_next = 15'(rgblab_pkg::L_MAX);
        end
        else
        begin
            l_next = lr[14:0];
        end

        if (ar > 28'sd32767)
        begin
            a_next = 16'sh7FFF;
        end
        else if (ar < -28'sd32768)
        begin
            a_next = -16'sh8000;
        end
        else
        begin
            a_next = ar[15:0];
        end

        if (br > 28'sd32767)
        begin
            b_next = 16'sh7FFF;
        end
        else if (br < -28'sd32768)
        begin
            b_next = -16'sh8000;
        end
        else
        begin
            b_next = br[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            c1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg         <= {v_reg[STEPS-2:0], in_valid};
            c1_valid_reg  <= v_reg[STEPS-1];
            out_valid_reg <= c1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l16_reg <= 28'sd116 * fy_s - 28'sd1048576;
            a16_reg <= 28'sd500 * (fx_s - fy_s);
            b16_reg <= 28'sd200 * (fy_s - fz_s);
            l_reg   <= l_next;
            a_reg   <= a_next;
            b_reg   <= b_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign lightness        = l_reg;
    assign green_red_axis   = a_reg;
    assign blue_yellow_axis = b_reg;

    a_l_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> l_reg <= 15'(rgblab_pkg::L_MAX))
        else $error("lightness out of range");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |=> out_valid_reg && $stable(l_reg) && $stable(a_reg))
        else $error("output word lost under stall");

endmodule

### rtl/rgb_to_cielab.sv
// Top level: sRGB pixel stream to CIELAB (D65) stream.
//
//  channel   dir  word                                  accepted when
//  s_axis    in   tdata[23:0] = red, green, blue        s_axis_tvalid & s_axis_tready
//  m_axis    out  tdata[46:0] = L*, a*, b* (Q8)         m_axis_tvalid & m_axis_tready
//
// One word per clock sustained while m_axis_tready is high; the front takes a pixel each cycle
// unless its queue is full. Path: 5 front stages, the queue, 17 cube-root stages, 2 output stages.
// The cube-root lanes (one result bit per stage) set the back pipeline depth.
// Reset clears all valid flags and queue pointers; payload registers are not reset.
// A stall at m_axis freezes the back; the queue absorbs words until full, then s_axis_tready drops.
`timescale 1ns / 1ps

module rgb_to_cielab #(
    parameter int FIFO_DEPTH = rgblab_pkg::FIFO_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red[7:0], green[15:8], blue[23:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata    // lightness[14:0], green_red_axis[30:15],
                                        // blue_yellow_axis[46:31], zero[47]
);

    rgblab_pkg::xyz_t         front_xyz;
    rgblab_pkg::xyz_t         fifo_xyz;
    rgblab_pkg::fifo_status_t fifo_st;
    logic                     front_valid;
    logic                     front_en;
    logic                     back_en;
    logic                     push;
    logic                     pop;
    logic [14:0]              lightness;
    logic signed [15:0]       green_red_axis;
    logic signed [15:0]       blue_yellow_axis;

    // front runs whenever the queue has room
    assign front_en      = !fifo_st.full;
    assign s_axis_tready = front_en;
    assign push          = front_en && front_valid;
    assign pop           = back_en && !fifo_st.empty;

    rgblab_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (front_en),
        .in_valid  (s_axis_tvalid),
        .red       (s_axis_tdata[7:0]),
        .green     (s_axis_tdata[15:8]),
        .blue      (s_axis_tdata[23:16]),
        .out_valid (front_valid),
        .xyz       (front_xyz)
    );

    rgblab_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .din    (front_xyz),
        .pop    (pop),
        .dout   (fifo_xyz),
        .status (fifo_st)
    );

    rgblab_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (pop),
        .xyz              (fifo_xyz),
        .en               (back_en),
        .out_valid        (m_axis_tvalid),
        .out_ready        (m_axis_tready),
        .lightness        (lightness),
        .green_red_axis   (green_red_axis),
        .blue_yellow_axis (blue_yellow_axis)
    );

    assign m_axis_tdata = {1'b0, blue_yellow_axis, green_red_axis, lightness};

endmodule
